// ----- rtl/core/pfc_seq_pkg.sv -----
// shared types and constants of the pfc contactor sequencer
`default_nettype none

package pfc_seq_pkg;

  // state codes
  localparam logic [3:0] ST_INIT        = 4'd0;
  localparam logic [3:0] ST_STOP        = 4'd1;
  localparam logic [3:0] ST_SYNC        = 4'd2;
  localparam logic [3:0] ST_PRE_PREP    = 4'd3;
  localparam logic [3:0] ST_PRECHARGE   = 4'd4;
  localparam logic [3:0] ST_MAIN        = 4'd5;
  localparam logic [3:0] ST_PRE_DISABLE = 4'd6;
  localparam logic [3:0] ST_WORK        = 4'd7;
  localparam logic [3:0] ST_CHARGE      = 4'd8;
  localparam logic [3:0] ST_TEST        = 4'd9;
  localparam logic [3:0] ST_STOPPING    = 4'd10;
  localparam logic [3:0] ST_FAULT       = 4'd11;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_FORCE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_PRECHARGE_VOLTAGE = 2'd0;
  localparam logic [1:0] REG_PHASE_TOLERANCE   = 2'd1;
  localparam logic [1:0] REG_MAIN_SETTLE       = 2'd2;
  localparam logic [1:0] REG_INIT_PERIODS      = 2'd3;

  // register reset values (phase tolerance is 0.03 rad in q3.12)
  localparam logic [15:0] PRECHARGE_VOLTAGE_RST = 16'd0;
  localparam logic [13:0] PHASE_TOLERANCE_RST   = 14'd123;
  localparam logic [15:0] MAIN_SETTLE_RST       = 16'd10;
  localparam logic [15:0] INIT_PERIODS_RST      = 16'd50;

  typedef struct packed {
    logic [3:0] code;
    logic [3:0] last;
    logic       main_closed;
    logic       pre_started;
    logic       pwm_on;
    logic       main_relay;
    logic       pre_relay;
    logic       fan;
  } seq_state_t;

  typedef struct packed {
    logic [3:0] current_state;
    logic       main_relay_on;
    logic       precharge_relay_on;
    logic       fans_on;
    logic       pwm_enabled;
    logic       clear_integrators;
    logic       state_event;
  } seq_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/pfc_seq_step.sv -----
// next-state and result logic for one sequencer item
`default_nettype none

module pfc_seq_step #(
  parameter int CNT_BITS = 32
) (
  input  var pfc_seq_pkg::seq_state_t  cur,
  input  wire logic [CNT_BITS-1:0]     period_count,
  input  wire logic [CNT_BITS-1:0]     main_close_time,
  input  wire logic [15:0]             precharge_voltage,
  input  wire logic [13:0]             phase_tolerance,
  input  wire logic [15:0]             main_settle_periods,
  input  wire logic [15:0]             init_periods,
  input  wire logic                    req_type,
  input  wire logic [3:0]              requested_state,
  input  wire logic [15:0]             bus_voltage,
  input  wire logic signed [14:0]      line_phase,
  input  wire logic                    period_offset_zero,
  output pfc_seq_pkg::seq_state_t      nxt,
  output logic [CNT_BITS-1:0]          main_close_time_next,
  output pfc_seq_pkg::seq_result_t     res
);

  logic [14:0]         phase_mag;
  logic [CNT_BITS-1:0] close_eff;
  logic [CNT_BITS-1:0] settle_diff;
  logic                clr;
  logic                evt;

  // magnitude of -16384 is 16384, which still fits unsigned in 15 bits
  assign phase_mag   = line_phase[14] ? (~line_phase + 15'd1) : line_phase;
  assign close_eff   = cur.main_closed ? main_close_time : period_count;
  assign settle_diff = period_count - close_eff;

  always_comb begin
    nxt                  = cur;
    main_close_time_next = main_close_time;
    clr                  = 1'b0;
    evt                  = 1'b0;
    if (req_type == pfc_seq_pkg::REQ_FORCE) begin
      if (requested_state <= pfc_seq_pkg::ST_FAULT) begin
        nxt.code = requested_state;
      end
    end else begin
      case (cur.code)
        pfc_seq_pkg::ST_INIT, pfc_seq_pkg::ST_STOP: begin
          nxt.main_relay  = 1'b0;
          nxt.pre_relay   = 1'b0;
          nxt.fan         = 1'b0;
          nxt.main_closed = 1'b0;
          nxt.pre_started = 1'b0;
          nxt.pwm_on      = 1'b0;
          if (cur.code == pfc_seq_pkg::ST_INIT &&
              period_count >= CNT_BITS'(init_periods)) begin
            nxt.code = pfc_seq_pkg::ST_STOP;
          end
        end
        pfc_seq_pkg::ST_SYNC: begin
          nxt.pwm_on = 1'b0;
          if (!(period_offset_zero && phase_mag > {1'b0, phase_tolerance})) begin
            nxt.code = pfc_seq_pkg::ST_PRE_PREP;
          end
        end
        pfc_seq_pkg::ST_PRE_PREP: begin
          nxt.pwm_on      = 1'b0;
          nxt.pre_started = 1'b0;
          nxt.code        = pfc_seq_pkg::ST_PRECHARGE;
        end
        pfc_seq_pkg::ST_PRECHARGE: begin
          nxt.pwm_on = 1'b0;
          if (bus_voltage > precharge_voltage) begin
            nxt.code = pfc_seq_pkg::ST_MAIN;
          end else if (!cur.pre_started) begin
            nxt.pre_relay   = 1'b1;
            nxt.pre_started = 1'b1;
          end
        end
        pfc_seq_pkg::ST_MAIN: begin
          nxt.pwm_on = 1'b0;
          if (!cur.main_closed) begin
            nxt.main_relay       = 1'b1;
            nxt.fan              = 1'b1;
            nxt.main_closed      = 1'b1;
            main_close_time_next = period_count;
          end
          if (settle_diff >= CNT_BITS'(main_settle_periods)) begin
            nxt.code = pfc_seq_pkg::ST_PRE_DISABLE;
          end
        end
        pfc_seq_pkg::ST_PRE_DISABLE: begin
          nxt.pre_relay   = 1'b0;
          nxt.pre_started = 1'b0;
          nxt.code        = pfc_seq_pkg::ST_WORK;
        end
        pfc_seq_pkg::ST_WORK: begin
          nxt.pwm_on = 1'b0;
        end
        pfc_seq_pkg::ST_CHARGE: begin
          if (!cur.pwm_on) begin
            clr        = 1'b1;
            nxt.pwm_on = 1'b1;
          end
        end
        pfc_seq_pkg::ST_STOPPING: begin
          nxt.main_relay = 1'b0;
          nxt.pre_relay  = 1'b0;
          nxt.fan        = 1'b0;
          nxt.code       = pfc_seq_pkg::ST_STOP;
        end
        pfc_seq_pkg::ST_FAULT: begin
          nxt.main_relay = 1'b0;
          nxt.pre_relay  = 1'b0;
          nxt.fan        = 1'b0;
          nxt.pwm_on     = 1'b0;
        end
        default: begin
        end
      endcase
      evt      = nxt.code != cur.last;
      nxt.last = nxt.code;
    end
  end

  always_comb begin
    res.current_state      = nxt.code;
    res.main_relay_on      = nxt.main_relay;
    res.precharge_relay_on = nxt.pre_relay;
    res.fans_on            = nxt.fan;
    res.pwm_enabled        = nxt.pwm_on;
    res.clear_integrators  = clr;
    res.state_event        = evt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pfc_contactor_sequencer_core.sv -----
// top level of the pfc contactor and precharge sequencer
// Contactor and precharge sequencer of a power-factor corrector. Each input transfer is
// either a control-period tick (bus voltage, line phase error, period-offset flag) or a
// command that forces a state code; each one yields exactly one result transfer with
// the state code, the latched main relay, precharge relay, fan and pwm drives, a
// clear-integrators pulse when pwm turns on in charge, and a state-event flag. The block
// takes one item per clock cycle while the result side is not stalled; each item passes
// through the input register, then the result register, and the next-state logic
// between them, with its period-counter subtract and compare, sets the clock limit.
// Stalls on the result side hold the result register and then the input register.
// Configuration writes are always ready and should be issued only while the block is
// idle. Codes 12 to 15 in a force command are ignored.
`default_nettype none

module pfc_contactor_sequencer_core #(
  parameter int PERIOD_COUNT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // item channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               req_type,
  input  wire logic [3:0]         requested_state,
  input  wire logic [15:0]        bus_voltage,
  input  wire logic signed [14:0] line_phase,
  input  wire logic               period_offset_zero,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              current_state,
  output logic                    main_relay_on,
  output logic                    precharge_relay_on,
  output logic                    fans_on,
  output logic                    pwm_enabled,
  output logic                    clear_integrators,
  output logic                    state_event,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // configuration registers
  logic [15:0] precharge_voltage;
  logic [13:0] phase_tolerance;
  logic [15:0] main_settle_periods;
  logic [15:0] init_periods;

  // input register
  logic               s1_valid;
  logic               s1_req_type;
  logic [3:0]         s1_requested_state;
  logic [15:0]        s1_bus_voltage;
  logic signed [14:0] s1_line_phase;
  logic               s1_period_offset_zero;

  // sequencer state
  pfc_seq_pkg::seq_state_t       state;
  pfc_seq_pkg::seq_state_t       state_next;
  logic [PERIOD_COUNT_BITS-1:0]  period_count;
  logic [PERIOD_COUNT_BITS-1:0]  main_close_time;
  logic [PERIOD_COUNT_BITS-1:0]  main_close_time_next;
  pfc_seq_pkg::seq_result_t      res;

  logic advance;
  logic in_xfer;

  // the input register moves whenever the result register is free or being drained
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      precharge_voltage   <= pfc_seq_pkg::PRECHARGE_VOLTAGE_RST;
      phase_tolerance     <= pfc_seq_pkg::PHASE_TOLERANCE_RST;
      main_settle_periods <= pfc_seq_pkg::MAIN_SETTLE_RST;
      init_periods        <= pfc_seq_pkg::INIT_PERIODS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfc_seq_pkg::REG_PRECHARGE_VOLTAGE: precharge_voltage   <= cfg_data;
        pfc_seq_pkg::REG_PHASE_TOLERANCE:   phase_tolerance     <= cfg_data[13:0];
        pfc_seq_pkg::REG_MAIN_SETTLE:       main_settle_periods <= cfg_data;
        pfc_seq_pkg::REG_INIT_PERIODS:      init_periods        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_type           <= req_type;
      s1_requested_state    <= requested_state;
      s1_bus_voltage        <= bus_voltage;
      s1_line_phase         <= line_phase;
      s1_period_offset_zero <= period_offset_zero;
    end
  end

  pfc_seq_step #(
    .CNT_BITS (PERIOD_COUNT_BITS)
  ) u_step (
    .cur                  (state),
    .period_count         (period_count),
    .main_close_time      (main_close_time),
    .precharge_voltage    (precharge_voltage),
    .phase_tolerance      (phase_tolerance),
    .main_settle_periods  (main_settle_periods),
    .init_periods         (init_periods),
    .req_type             (s1_req_type),
    .requested_state      (s1_requested_state),
    .bus_voltage          (s1_bus_voltage),
    .line_phase           (s1_line_phase),
    .period_offset_zero   (s1_period_offset_zero),
    .nxt                  (state_next),
    .main_close_time_next (main_close_time_next),
    .res                  (res)
  );

  // state update, one item per advance; the period counter counts ticks only
  always_ff @(posedge clk) begin
    if (rst) begin
      state.code         <= pfc_seq_pkg::ST_INIT;
      state.last         <= pfc_seq_pkg::ST_INIT;
      state.main_closed  <= 1'b0;
      state.pre_started  <= 1'b0;
      state.pwm_on       <= 1'b0;
      state.main_relay   <= 1'b0;
      state.pre_relay    <= 1'b0;
      state.fan          <= 1'b0;
      period_count       <= '0;
      main_close_time    <= '0;
    end else if (advance) begin
      state           <= state_next;
      main_close_time <= main_close_time_next;
      if (s1_req_type == pfc_seq_pkg::REQ_TICK) begin
        period_count <= period_count + PERIOD_COUNT_BITS'(1);
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      current_state      <= res.current_state;
      main_relay_on      <= res.main_relay_on;
      precharge_relay_on <= res.precharge_relay_on;
      fans_on            <= res.fans_on;
      pwm_enabled        <= res.pwm_enabled;
      clear_integrators  <= res.clear_integrators;
      state_event        <= res.state_event;
    end
  end

  // a tick in fault block leaves every drive off
  a_fault_all_off: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_req_type == pfc_seq_pkg::REQ_TICK && state.code == pfc_seq_pkg::ST_FAULT)
    |=> (!main_relay_on && !precharge_relay_on && !fans_on && !pwm_enabled))
    else $error("drive left on in fault block");

  // integrator clear only comes with pwm on in charge
  a_clear_in_charge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_integrators)
    |-> (pwm_enabled && current_state == pfc_seq_pkg::ST_CHARGE))
    else $error("integrator clear outside charge");

  // a force command never flags an event or clears integrators
  a_force_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_req_type == pfc_seq_pkg::REQ_FORCE)
    |=> (!state_event && !clear_integrators))
    else $error("force command raised a pulse");

  // each tick moves the period counter by exactly one
  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_req_type == pfc_seq_pkg::REQ_TICK)
    |=> (period_count == $past(period_count) + PERIOD_COUNT_BITS'(1)))
    else $error("period counter did not advance on tick");

endmodule

`default_nettype wire
